### hw/rtl/alms_pkg.sv
// ----------------------------------------------------------------------------
// alms_pkg
// Shared constants, codes and types of the linked multiset core.
// ----------------------------------------------------------------------------
package alms_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int LINK_W      = $clog2(CAPACITY + 1);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int OUT_W       = 7;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

    // command codes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_COUNT  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    typedef struct packed {
        logic [1:0]             op;
        logic [VALUE_WIDTH-1:0] value;
    } cmd_word_t;

    typedef struct packed {
        logic      valid;
        cmd_word_t word;
    } queue_head_t;

    function automatic logic link_ok(input logic [LINK_W-1:0] l);
        return l < NULL_LINK;
    endfunction

endpackage

### hw/rtl/alms_cmd_if.sv
// ----------------------------------------------------------------------------
// alms_cmd_if
// Command channel: operation code and value, valid/ready handshake.
// ----------------------------------------------------------------------------
interface alms_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

### hw/rtl/alms_res_if.sv
// ----------------------------------------------------------------------------
// alms_res_if
// Result channel: success flag, frequency and entry count.
// ----------------------------------------------------------------------------
interface alms_res_if;
    logic       valid;
    logic       ready;
    logic       ok;
    logic [6:0] frequency;
    logic [6:0] entry_count;

    modport source (output valid, output ok, output frequency, output entry_count,
                    input ready);
    modport sink   (input valid, input ok, input frequency, input entry_count,
                    output ready);
endinterface

### hw/rtl/array_linked_multiset_core.sv
// Sequence: clear answers straight from idle; add walks, acts, then ADD1, ADD2 and DONE;
// remove walks, acts, then RM1, RM2 and DONE (straight to DONE when absent); count walks,
// acts and ends in DONE. The walk visits the held entries, one slot read per cycle. The back
// end works on one word at a time; a two-entry command queue keeps accepting until full.
// Reset: asynchronous active low; list empty, all slots on the free chain.
// ----------------------------------------------------------------------------
// array_linked_multiset_core
// Bounded multiset kept as a doubly linked list in slot memories.
// ----------------------------------------------------------------------------
module array_linked_multiset_core (
    input  logic        clk,
    input  logic        rst_n,
    alms_cmd_if.sink    req,
    alms_res_if.source  rsp
);
    import alms_pkg::*;

    queue_head_t q_head;
    logic        q_pop;

    // command intake and queue
    alms_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .pop   (q_pop),
        .head  (q_head)
    );

    // list engine
    alms_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (q_head),
        .pop   (q_pop),
        .rsp   (rsp)
    );

endmodule

### hw/rtl/alms_front.sv
// ----------------------------------------------------------------------------
// alms_front
// Accepts command words, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module alms_front (
    input  logic                 clk,
    input  logic                 rst_n,
    alms_cmd_if.sink             req,
    input  logic                 pop,
    output alms_pkg::queue_head_t head
);
    import alms_pkg::*;

    cmd_word_t   fifo_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  level_reg;
    logic [1:0]  level_next;
    logic        push;
    logic        do_pop;
    cmd_word_t   in_word;

    // decode incoming word
    always_comb
    begin
        in_word.value = req.value[VALUE_WIDTH-1:0];
        unique case (req.cmd)
            OP_ADD:    in_word.op = OP_ADD;
            OP_REMOVE: in_word.op = OP_REMOVE;
            OP_COUNT:  in_word.op = OP_COUNT;
            default:   in_word.op = OP_CLEAR;
        endcase
    end

    assign req.ready  = (level_reg != 2'd2);
    assign push       = req.valid && req.ready;
    assign do_pop     = pop && (level_reg != 2'd0);
    assign head.valid = (level_reg != 2'd0);
    assign head.word  = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        level_next = level_reg;
        if (push && !do_pop)
        begin
            level_next = level_reg + 2'd1;
        end
        else if (do_pop && !push)
        begin
            level_next = level_reg - 2'd1;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= in_word;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            level_reg <= level_next;
        end
    end

endmodule

### hw/rtl/alms_back.sv
// ----------------------------------------------------------------------------
// alms_back
// Executes commands on the linked list held in slot memories.
// ----------------------------------------------------------------------------
module alms_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  alms_pkg::queue_head_t head,
    output logic                  pop,
    alms_res_if.source            rsp
);
    import alms_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WALK = 3'd1;
    localparam logic [2:0] ST_ACT  = 3'd2;
    localparam logic [2:0] ST_ADD1 = 3'd3;
    localparam logic [2:0] ST_ADD2 = 3'd4;
    localparam logic [2:0] ST_RM1  = 3'd5;
    localparam logic [2:0] ST_RM2  = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    // slot memories
    logic [VALUE_WIDTH-1:0] item_mem [CAPACITY];
    logic [LINK_W-1:0]      nl_mem   [CAPACITY];
    logic [LINK_W-1:0]      pl_mem   [CAPACITY];

    logic [2:0]             state_reg, state_next;
    logic [1:0]             op_reg, op_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [CNT_W-1:0]       seen_reg, seen_next;
    logic [CNT_W-1:0]       freq_reg, freq_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       slot_reg, slot_next;
    logic [LINK_W-1:0]      p_reg, p_next;
    logic [LINK_W-1:0]      n_reg, n_next;
    logic                   ok_reg, ok_next;
    logic [LINK_W-1:0]      lhead_reg, lhead_next;
    logic [LINK_W-1:0]      free_reg, free_next;
    logic [CNT_W-1:0]       held_reg, held_next;
    logic [CAPACITY-1:0]    nv_reg, nv_next;
    logic [CAPACITY-1:0]    pv_reg, pv_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    logic                   rsp_ok_reg, rsp_ok_next;
    logic [OUT_W-1:0]       rsp_freq_reg, rsp_freq_next;
    logic [OUT_W-1:0]       rsp_cnt_reg, rsp_cnt_next;

    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       rd_addr_reg;
    logic [VALUE_WIDTH-1:0] item_rd_reg;
    logic [LINK_W-1:0]      nl_rd_reg;
    logic [LINK_W-1:0]      pl_rd_reg;
    logic                   nv_rd_reg;
    logic                   pv_rd_reg;
    logic [LINK_W-1:0]      nl_eff;
    logic [LINK_W-1:0]      pl_eff;

    logic                   item_we;
    logic [IDX_W-1:0]       item_wa;
    logic                   nl_we;
    logic [IDX_W-1:0]       nl_wa;
    logic [LINK_W-1:0]      nl_wd;
    logic                   pl_we;
    logic [IDX_W-1:0]       pl_wa;
    logic [LINK_W-1:0]      pl_wd;

    // never-written links read as their reset value
    assign nl_eff = nv_rd_reg ? nl_rd_reg : (LINK_W'(rd_addr_reg) + LINK_W'(1));
    assign pl_eff = pv_rd_reg ? pl_rd_reg : NULL_LINK;

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.ok          = rsp_ok_reg;
    assign rsp.frequency   = rsp_freq_reg;
    assign rsp.entry_count = rsp_cnt_reg;

    // command sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        seen_next      = seen_reg;
        freq_next      = freq_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        p_next         = p_reg;
        n_next         = n_reg;
        ok_next        = ok_reg;
        lhead_next     = lhead_reg;
        free_next      = free_reg;
        held_next      = held_reg;
        nv_next        = nv_reg;
        pv_next        = pv_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_ok_next    = rsp_ok_reg;
        rsp_freq_next  = rsp_freq_reg;
        rsp_cnt_next   = rsp_cnt_reg;
        pop            = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = lhead_reg[IDX_W-1:0];
        item_we        = 1'b0;
        item_wa        = slot_reg;
        nl_we          = 1'b0;
        nl_wa          = slot_reg;
        nl_wd          = lhead_reg;
        pl_we          = 1'b0;
        pl_wa          = slot_reg;
        pl_wd          = NULL_LINK;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid && !rsp_valid_reg)
                begin
                    pop        = 1'b1;
                    op_next    = head.word.op;
                    val_next   = head.word.value;
                    freq_next  = '0;
                    found_next = 1'b0;
                    seen_next  = '0;
                    if (head.word.op == OP_CLEAR)
                    begin
                        lhead_next     = NULL_LINK;
                        free_next      = '0;
                        held_next      = '0;
                        nv_next        = '0;
                        pv_next        = '0;
                        rsp_valid_next = 1'b1;
                        rsp_ok_next    = 1'b1;
                        rsp_freq_next  = '0;
                        rsp_cnt_next   = '0;
                    end
                    else if (link_ok(lhead_reg) && (held_reg != '0))
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = lhead_reg[IDX_W-1:0];
                        seen_next  = CNT_W'(1);
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_ACT;
                    end
                end
            end

            // one slot compared per cycle, next read issued from the link
            ST_WALK:
            begin
                if (item_rd_reg == val_reg)
                begin
                    freq_next = freq_reg + CNT_W'(1);
                    if (!found_reg)
                    begin
                        found_next = 1'b1;
                        slot_next  = rd_addr_reg;
                        p_next     = pl_eff;
                        n_next     = nl_eff;
                    end
                end
                if (link_ok(nl_eff) && (seen_reg < held_reg))
                begin
                    rd_en     = 1'b1;
                    rd_addr   = nl_eff[IDX_W-1:0];
                    seen_next = seen_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = ST_ACT;
                end
            end

            ST_ACT:
            begin
                unique case (op_reg)
                    OP_ADD:
                    begin
                        if ((held_reg < CNT_W'(CAPACITY)) && link_ok(free_reg))
                        begin
                            slot_next  = free_reg[IDX_W-1:0];
                            rd_en      = 1'b1;
                            rd_addr    = free_reg[IDX_W-1:0];
                            state_next = ST_ADD1;
                        end
                        else
                        begin
                            ok_next    = 1'b0;
                            state_next = ST_DONE;
                        end
                    end
                    OP_REMOVE:
                    begin
                        ok_next    = 1'b0;
                        state_next = found_reg ? ST_RM1 : ST_DONE;
                    end
                    default:
                    begin
                        ok_next    = (freq_reg != '0);
                        state_next = ST_DONE;
                    end
                endcase
            end

            // take the free slot, link it in front of the old head
            ST_ADD1:
            begin
                item_we         = 1'b1;
                item_wa         = slot_reg;
                nl_we           = 1'b1;
                nl_wa           = slot_reg;
                nl_wd           = lhead_reg;
                pl_we           = 1'b1;
                pl_wa           = slot_reg;
                pl_wd           = NULL_LINK;
                nv_next[slot_reg] = 1'b1;
                pv_next[slot_reg] = 1'b1;
                free_next       = nl_eff;
                state_next      = ST_ADD2;
            end

            ST_ADD2:
            begin
                if (link_ok(lhead_reg))
                begin
                    pl_we = 1'b1;
                    pl_wa = lhead_reg[IDX_W-1:0];
                    pl_wd = LINK_W'(slot_reg);
                    pv_next[lhead_reg[IDX_W-1:0]] = 1'b1;
                end
                lhead_next = LINK_W'(slot_reg);
                held_next  = held_reg + CNT_W'(1);
                freq_next  = freq_reg + CNT_W'(1);
                ok_next    = 1'b1;
                state_next = ST_DONE;
            end

            // unlink the first match
            ST_RM1:
            begin
                if (link_ok(p_reg))
                begin
                    nl_we = 1'b1;
                    nl_wa = p_reg[IDX_W-1:0];
                    nl_wd = n_reg;
                    nv_next[p_reg[IDX_W-1:0]] = 1'b1;
                end
                else
                begin
                    lhead_next = n_reg;
                end
                pl_we           = 1'b1;
                pl_wa           = slot_reg;
                pl_wd           = NULL_LINK;
                pv_next[slot_reg] = 1'b1;
                state_next      = ST_RM2;
            end

            // fix the successor's back link and return the slot to the free list
            ST_RM2:
            begin
                if (link_ok(n_reg))
                begin
                    pl_we = 1'b1;
                    pl_wa = n_reg[IDX_W-1:0];
                    pl_wd = p_reg;
                    pv_next[n_reg[IDX_W-1:0]] = 1'b1;
                end
                nl_we           = 1'b1;
                nl_wa           = slot_reg;
                nl_wd           = free_reg;
                nv_next[slot_reg] = 1'b1;
                free_next       = LINK_W'(slot_reg);
                held_next       = held_reg - CNT_W'(1);
                freq_next       = freq_reg - CNT_W'(1);
                ok_next         = 1'b1;
                state_next      = ST_DONE;
            end

            ST_DONE:
            begin
                rsp_valid_next = 1'b1;
                rsp_ok_next    = ok_reg;
                rsp_freq_next  = OUT_W'(freq_reg);
                rsp_cnt_next   = OUT_W'(held_reg);
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (item_we)
        begin
            item_mem[item_wa] <= val_reg;
        end
        if (nl_we)
        begin
            nl_mem[nl_wa] <= nl_wd;
        end
        if (pl_we)
        begin
            pl_mem[pl_wa] <= pl_wd;
        end
        if (rd_en)
        begin
            item_rd_reg <= item_mem[rd_addr];
            nl_rd_reg   <= nl_mem[rd_addr];
            pl_rd_reg   <= pl_mem[rd_addr];
            nv_rd_reg   <= nv_reg[rd_addr];
            pv_rd_reg   <= pv_reg[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        val_reg       <= val_next;
        seen_reg      <= seen_next;
        freq_reg      <= freq_next;
        found_reg     <= found_next;
        slot_reg      <= slot_next;
        p_reg         <= p_next;
        n_reg         <= n_next;
        ok_reg        <= ok_next;
        rsp_ok_reg    <= rsp_ok_next;
        rsp_freq_reg  <= rsp_freq_next;
        rsp_cnt_reg   <= rsp_cnt_next;
    end

    // control and list state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lhead_reg     <= NULL_LINK;
            free_reg      <= '0;
            held_reg      <= '0;
            nv_reg        <= '0;
            pv_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lhead_reg     <= lhead_next;
            free_reg      <= free_next;
            held_reg      <= held_next;
            nv_reg        <= nv_next;
            pv_reg        <= pv_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

### hw/rtl/alms_check.sv
// ----------------------------------------------------------------------------
// alms_check
// Port-level checks of the multiset core results.
// ----------------------------------------------------------------------------
module alms_check (
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       rsp_ok,
    input logic [6:0] rsp_frequency,
    input logic [6:0] rsp_entry_count
);
    import alms_pkg::*;

    // stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok)
            && $stable(rsp_frequency) && $stable(rsp_entry_count))
        else $error("result word changed while stalled");

    // entry count bounded by capacity
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_entry_count <= 7'(CAPACITY))
        else $error("entry count above capacity");

    // occurrences never exceed held entries
    a_freq: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_frequency <= rsp_entry_count)
        else $error("frequency above entry count");

    // empty bag (entry count zero) implies frequency zero
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_entry_count == 7'd0 |-> rsp_frequency == 7'd0)
        else $error("frequency on empty bag");

endmodule

bind array_linked_multiset_core alms_check u_alms_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_ok          (rsp.ok),
    .rsp_frequency   (rsp.frequency),
    .rsp_entry_count (rsp.entry_count)
);
